>>> design/bcp_pkg.sv
`default_nettype none
package bcp_pkg;

    // Default sizes of the clause store
    localparam int unsigned CLAUSES_DEF   = 1024;
    localparam int unsigned LITS_DEF      = 4;
    localparam int unsigned VAR_W_DEF     = 10;

    // Fixed port field widths
    localparam int unsigned FUNC_W   = 2;
    localparam int unsigned IDX_W    = 12;
    localparam int unsigned VAR_IN_W = 10;
    localparam int unsigned VAL_W    = 2;
    localparam int unsigned CID_W    = 10;
    localparam int unsigned POS_W    = 2;

    // Command codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ASSIGN = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_UNDO   = 2'd2;

    // Three-valued literal values
    localparam logic [VAL_W-1:0] VAL_FALSE      = 2'd0;
    localparam logic [VAL_W-1:0] VAL_TRUE       = 2'd1;
    localparam logic [VAL_W-1:0] VAL_UNASSIGNED = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD_DIV,
        S_LOAD_RD,
        S_LOAD_WR,
        S_SWEEP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic clear_step;
        logic load_div;
        logic load_rd;
        logic load_wr;
        logic sweep_step;
        logic result_load;
    } t_cmd;

    typedef struct packed {
        logic cnt_end;
        logic out_busy;
    } t_status;

endpackage
`default_nettype wire

>>> design/bcp_ram.sv
`default_nettype none
module bcp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

>>> design/bcp_ctrl.sv
`default_nettype none
module bcp_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic [bcp_pkg::FUNC_W-1:0]    i_func,
    input  wire bcp_pkg::t_status              i_status,
    output bcp_pkg::t_cmd                      o_cmd,
    output logic                               o_stall
);
    import bcp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_status.cnt_end) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    case (i_func)
                        FUNC_LOAD:   n_state = S_LOAD_DIV;
                        FUNC_ASSIGN: n_state = S_SWEEP;
                        FUNC_UNDO:   n_state = S_SWEEP;
                        default:     n_state = S_DONE;
                    endcase
                end
            end
            S_LOAD_DIV: n_state = S_LOAD_RD;
            S_LOAD_RD:  n_state = S_LOAD_WR;
            S_LOAD_WR:  n_state = S_DONE;
            S_SWEEP: begin
                if (i_status.cnt_end) n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_status.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd             = '0;
        o_stall           = 1'b1;
        case (r_state)
            S_CLEAR:    o_cmd.clear_step = !i_status.cnt_end;
            S_IDLE: begin
                o_stall      = 1'b0;
                o_cmd.accept = i_valid;
            end
            S_LOAD_DIV: o_cmd.load_div = 1'b1;
            S_LOAD_RD:  o_cmd.load_rd = 1'b1;
            S_LOAD_WR:  o_cmd.load_wr = 1'b1;
            S_SWEEP:    o_cmd.sweep_step = !i_status.cnt_end;
            S_DONE:     o_cmd.result_load = !i_status.out_busy;
            default:    o_stall = 1'b1;
        endcase
    end
endmodule
`default_nettype wire

>>> design/bcp_dp.sv
`default_nettype none
module bcp_dp #(
    parameter int unsigned CLAUSES         = bcp_pkg::CLAUSES_DEF,
    parameter int unsigned LITS_PER_CLAUSE = bcp_pkg::LITS_DEF,
    parameter int unsigned VAR_ID_WIDTH    = bcp_pkg::VAR_W_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire bcp_pkg::t_cmd                  i_cmd,
    output bcp_pkg::t_status                    o_status,
    input  wire logic [bcp_pkg::FUNC_W-1:0]     i_func,
    input  wire logic [bcp_pkg::IDX_W-1:0]      i_row_index,
    input  wire logic [bcp_pkg::VAR_IN_W-1:0]   i_var_id,
    input  wire logic                           i_negated,
    input  wire logic [bcp_pkg::VAL_W-1:0]      i_value,
    input  wire logic                           i_stall,
    output logic                                o_valid,
    output logic                                o_conflict,
    output logic                                o_unit_found,
    output logic                                o_quiet,
    output logic [bcp_pkg::CID_W-1:0]           o_clause_id,
    output logic [bcp_pkg::POS_W-1:0]           o_unit_position,
    output logic [bcp_pkg::VAR_IN_W-1:0]        o_unit_var,
    output logic                                o_unit_negated
);
    import bcp_pkg::*;

    localparam int unsigned CW         = $clog2(CLAUSES);
    localparam int unsigned LPW        = $clog2(LITS_PER_CLAUSE);
    localparam int unsigned CNTW       = $clog2(LITS_PER_CLAUSE + 1);
    localparam int unsigned VW         = VAR_ID_WIDTH;
    localparam int unsigned LW         = VW + 4;
    localparam int unsigned WW         = LW * LITS_PER_CLAUSE;
    localparam int unsigned ROWS       = CLAUSES * LITS_PER_CLAUSE;
    localparam int unsigned DIV_SHIFT  = 20;
    localparam int unsigned DIV_MULT   = (1 << DIV_SHIFT) / LITS_PER_CLAUSE + 1;
    // Literal layout: {valid, value[1:0], negated, var}
    localparam int unsigned NEG_B      = VW;
    localparam int unsigned VAL_B      = VW + 1;
    localparam int unsigned VLD_B      = VW + 3;

    // Captured command
    logic [FUNC_W-1:0] r_func;
    logic [IDX_W-1:0]  r_idx;
    logic [VW-1:0]     r_var;
    logic              r_neg;
    logic [VAL_W-1:0]  r_val;
    logic [VW-1:0]     var_k;
    logic [VAL_W-1:0]  val_k;

    // Load address split
    logic [IDX_W-1:0]  r_q;
    logic              r_inr;
    logic [LPW-1:0]    r_rem;
    logic [31:0]       prod;
    logic [IDX_W-1:0]  qmul;

    // Sweep counter and read pipeline
    logic [CW:0]       r_cnt;
    logic              r_p_vld;
    logic [CW-1:0]     r_p_addr;

    // RAM ports
    logic              ram_we;
    logic [CW-1:0]     ram_waddr;
    logic [WW-1:0]     ram_wdata;
    logic              ram_re;
    logic [CW-1:0]     ram_raddr;
    logic [WW-1:0]     ram_rdata;

    // Clause evaluation
    logic [WW-1:0]     upd;
    logic [WW-1:0]     load_word;
    logic              any_true;
    logic              loaded;
    logic [CNTW-1:0]   n_un;
    logic [LPW-1:0]    un_pos;
    logic [VW-1:0]     un_var;
    logic              un_neg;
    logic [LW-1:0]     lit;
    logic              is_conf;
    logic              is_unit;

    // Running results
    logic              r_conf;
    logic              r_unit;
    logic [CW-1:0]     r_conf_cid;
    logic [CW-1:0]     r_unit_cid;
    logic [LPW-1:0]    r_upos;
    logic [VW-1:0]     r_uvar;
    logic              r_uneg;

    // Fit the variable number to the stored width
    generate
        if (VW <= VAR_IN_W) begin : g_var_trunc
            assign var_k = i_var_id[VW-1:0];
        end else begin : g_var_ext
            assign var_k = {{(VW - VAR_IN_W){1'b0}}, i_var_id};
        end
    endgenerate

    assign val_k = (i_value == VAL_FALSE || i_value == VAL_TRUE) ? i_value : VAL_UNASSIGNED;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func <= i_func;
            r_idx  <= i_row_index;
            r_var  <= var_k;
            r_neg  <= i_negated;
            r_val  <= (i_func == FUNC_UNDO) ? VAL_UNASSIGNED : val_k;
        end
    end

    // Divide the row index by the literal count through a reciprocal multiply
    assign prod = 32'(r_idx) * 32'(DIV_MULT);
    assign qmul = prod[DIV_SHIFT +: IDX_W];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_div) begin
            r_q   <= qmul;
            r_inr <= (32'(r_idx) < 32'(ROWS));
        end
        if (i_cmd.load_rd) begin
            r_rem <= LPW'(r_idx - IDX_W'(32'(r_q) * 32'(LITS_PER_CLAUSE)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= i_cmd.sweep_step;
            if (i_cmd.accept) begin
                r_cnt <= '0;
            end else if (i_cmd.clear_step || i_cmd.sweep_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_addr <= r_cnt[CW-1:0];
    end

    assign o_status.cnt_end  = (r_cnt == (CW+1)'(CLAUSES));
    assign o_status.out_busy = o_valid && i_stall;

    // Write back each swept clause with the new variable value and evaluate it
    always_comb begin
        upd      = ram_rdata;
        any_true = 1'b0;
        loaded   = 1'b0;
        n_un     = '0;
        un_pos   = '0;
        un_var   = '0;
        un_neg   = 1'b0;
        lit      = '0;
        for (int p = 0; p < LITS_PER_CLAUSE; p++) begin
            lit = ram_rdata[p*LW +: LW];
            if (lit[VLD_B] && lit[VW-1:0] == r_var) begin
                lit[VAL_B +: VAL_W] = r_val;
            end
            upd[p*LW +: LW] = lit;
            if (lit[VLD_B]) begin
                loaded = 1'b1;
                if (lit[VAL_B +: VAL_W] == VAL_UNASSIGNED) begin
                    n_un   = n_un + CNTW'(1);
                    un_pos = LPW'(p);
                    un_var = lit[VW-1:0];
                    un_neg = lit[NEG_B];
                end else if (lit[VAL_B +: VAL_W] == (lit[NEG_B] ? VAL_FALSE : VAL_TRUE)) begin
                    any_true = 1'b1;
                end
            end
        end
    end

    assign is_conf = loaded && !any_true && (n_un == '0);
    assign is_unit = loaded && !any_true && (n_un == CNTW'(1));

    always_comb begin
        load_word = ram_rdata;
        for (int p = 0; p < LITS_PER_CLAUSE; p++) begin
            if (r_rem == LPW'(p)) begin
                load_word[p*LW +: LW] = {1'b1, r_val, r_neg, r_var};
            end
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cnt[CW-1:0];
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = r_cnt[CW-1:0];
        if (i_cmd.clear_step) begin
            ram_we = 1'b1;
        end else if (r_p_vld) begin
            ram_we    = 1'b1;
            ram_waddr = r_p_addr;
            ram_wdata = upd;
        end else if (i_cmd.load_wr) begin
            ram_we    = r_inr;
            ram_waddr = r_q[CW-1:0];
            ram_wdata = load_word;
        end
        if (i_cmd.sweep_step) begin
            ram_re = 1'b1;
        end else if (i_cmd.load_rd) begin
            ram_re    = 1'b1;
            ram_raddr = r_q[CW-1:0];
        end
    end

    bcp_ram #(
        .WIDTH (WW),
        .DEPTH (CLAUSES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Keep the first conflict and the first unit clause in sweep order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conf <= 1'b0;
            r_unit <= 1'b0;
        end else if (i_cmd.accept) begin
            r_conf <= 1'b0;
            r_unit <= 1'b0;
        end else if (r_p_vld && r_func == FUNC_ASSIGN) begin
            if (is_conf && !r_conf) r_conf <= 1'b1;
            if (is_unit && !r_unit) r_unit <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p_vld && is_conf && !r_conf) begin
            r_conf_cid <= r_p_addr;
        end
        if (r_p_vld && is_unit && !r_unit) begin
            r_unit_cid <= r_p_addr;
            r_upos     <= un_pos;
            r_uvar     <= un_var;
            r_uneg     <= un_neg;
        end
    end

    // Output register
    logic [CW-1:0]       sel_cid;
    logic [CID_W-1:0]    cid_out;
    logic [POS_W-1:0]    pos_out;
    logic [VAR_IN_W-1:0] var_out;

    assign sel_cid = r_conf ? r_conf_cid : r_unit_cid;

    generate
        if (CW >= CID_W) begin : g_cid_trunc
            assign cid_out = sel_cid[CID_W-1:0];
        end else begin : g_cid_ext
            assign cid_out = {{(CID_W - CW){1'b0}}, sel_cid};
        end
        if (LPW >= POS_W) begin : g_pos_trunc
            assign pos_out = r_upos[POS_W-1:0];
        end else begin : g_pos_ext
            assign pos_out = {{(POS_W - LPW){1'b0}}, r_upos};
        end
        if (VW >= VAR_IN_W) begin : g_uvar_trunc
            assign var_out = r_uvar[VAR_IN_W-1:0];
        end else begin : g_uvar_ext
            assign var_out = {{(VAR_IN_W - VW){1'b0}}, r_uvar};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.result_load) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.result_load) begin
            o_conflict      <= r_conf;
            o_unit_found    <= !r_conf && r_unit;
            o_quiet         <= !r_conf && !r_unit;
            o_clause_id     <= (r_conf || r_unit) ? cid_out : '0;
            o_unit_position <= (!r_conf && r_unit) ? pos_out : '0;
            o_unit_var      <= (!r_conf && r_unit) ? var_out : '0;
            o_unit_negated  <= !r_conf && r_unit && r_uneg;
        end
    end
endmodule
`default_nettype wire

>>> design/clause_bcp_engine_core.sv
// Clause store for Boolean constraint propagation.
// Input channel (i_valid / o_stall) carries one command: load a literal row,
// assign a variable and evaluate all clauses, or undo a variable.
// Output channel (o_valid / i_stall) returns exactly one result per command:
// conflict, unit clause (with the implied literal) or quiet.
// Clauses live in one RAM word per clause, read-modify-written by a sweep.
// A load passes through the states LOAD_DIV, LOAD_RD and LOAD_WR before its
// result shows; assign and undo sweep the RAM one clause per cycle.
// Unknown command codes go straight to the result state and return quiet.
// One command is in flight at a time; the next transfer is taken in the
// cycle after the result is loaded into the output register, even while
// that result is still held by a stalling receiver.
// After reset the block runs a clearing pass over the store with o_stall
// high. A stalled result holds until taken, and the block waits with its
// next result until the output register is free.
`default_nettype none
module clause_bcp_engine_core #(
    parameter int unsigned CLAUSES         = bcp_pkg::CLAUSES_DEF,
    parameter int unsigned LITS_PER_CLAUSE = bcp_pkg::LITS_DEF,
    parameter int unsigned VAR_ID_WIDTH    = bcp_pkg::VAR_W_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [bcp_pkg::FUNC_W-1:0]     i_func,
    input  wire logic [bcp_pkg::IDX_W-1:0]      i_row_index,
    input  wire logic [bcp_pkg::VAR_IN_W-1:0]   i_var_id,
    input  wire logic                           i_negated,
    input  wire logic [bcp_pkg::VAL_W-1:0]      i_value,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic                                o_conflict,
    output logic                                o_unit_found,
    output logic                                o_quiet,
    output logic [bcp_pkg::CID_W-1:0]           o_clause_id,
    output logic [bcp_pkg::POS_W-1:0]           o_unit_position,
    output logic [bcp_pkg::VAR_IN_W-1:0]        o_unit_var,
    output logic                                o_unit_negated
);
    import bcp_pkg::*;

    t_cmd    cmd;
    t_status status;

    bcp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_func   (i_func),
        .i_status (status),
        .o_cmd    (cmd),
        .o_stall  (o_stall)
    );

    bcp_dp #(
        .CLAUSES         (CLAUSES),
        .LITS_PER_CLAUSE (LITS_PER_CLAUSE),
        .VAR_ID_WIDTH    (VAR_ID_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_func          (i_func),
        .i_row_index     (i_row_index),
        .i_var_id        (i_var_id),
        .i_negated       (i_negated),
        .i_value         (i_value),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_conflict      (o_conflict),
        .o_unit_found    (o_unit_found),
        .o_quiet         (o_quiet),
        .o_clause_id     (o_clause_id),
        .o_unit_position (o_unit_position),
        .o_unit_var      (o_unit_var),
        .o_unit_negated  (o_unit_negated)
    );
endmodule
`default_nettype wire

>>> design/bcp_checker.sv
`default_nettype none
module bcp_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_valid,
    input wire logic                           o_stall,
    input wire logic                           o_valid,
    input wire logic                           i_stall,
    input wire logic                           o_conflict,
    input wire logic                           o_unit_found,
    input wire logic                           o_quiet,
    input wire logic [bcp_pkg::CID_W-1:0]      o_clause_id,
    input wire logic [bcp_pkg::POS_W-1:0]      o_unit_position,
    input wire logic [bcp_pkg::VAR_IN_W-1:0]   o_unit_var,
    input wire logic                           o_unit_negated
);
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot({o_conflict, o_unit_found, o_quiet}))
        else $error("result kind not one-hot");

    a_quiet_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_quiet) |-> (o_clause_id == '0))
        else $error("quiet result carries a clause id");

    a_unit_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_unit_found) |->
            (o_unit_position == '0 && o_unit_var == '0 && !o_unit_negated))
        else $error("implied literal shown without a unit clause");

    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("second transfer taken while a command is in flight");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_clause_id)))
        else $error("stalled result changed");
endmodule

bind clause_bcp_engine_core bcp_checker u_bcp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_conflict      (o_conflict),
    .o_unit_found    (o_unit_found),
    .o_quiet         (o_quiet),
    .o_clause_id     (o_clause_id),
    .o_unit_position (o_unit_position),
    .o_unit_var      (o_unit_var),
    .o_unit_negated  (o_unit_negated)
);
`default_nettype wire
